// ===== sv/lmgs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// LED matrix glyph scanner package
// Shared constants, step types and the character-to-glyph decode.
// ============================================================================
package lmgs_pkg;

    localparam int GLYPH_COUNT = 38;
    localparam int GLYPH_W     = 6;
    localparam int ROW_W       = 3;
    localparam int ADDR_W      = GLYPH_W + ROW_W;
    localparam int STORE_DEPTH = GLYPH_COUNT * 8;
    localparam int PHASE_W     = 5;

    // Item kinds on the cmd field
    localparam logic CMD_SCAN = 1'b0;
    localparam logic CMD_LOAD = 1'b1;

    // Register byte addresses
    localparam logic [1:0] REG_DISPLAY_CHAR = 2'd0;

    localparam logic [PHASE_W-1:0] PHASE_ROW_START = PHASE_W'(8);
    localparam logic [PHASE_W-1:0] PHASE_LATCH     = PHASE_W'(16);

    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [7:0] CHAR_DIGIT_0 = 8'h30;
    localparam logic [7:0] CHAR_DIGIT_9 = 8'h39;
    localparam logic [7:0] CHAR_SPACE   = 8'h20;
    localparam logic [7:0] CHAR_AMP     = 8'h26;

    localparam logic [GLYPH_W-1:0] GLYPH_DIGIT_BASE = GLYPH_W'(26);
    localparam logic [GLYPH_W-1:0] GLYPH_SPACE      = GLYPH_W'(36);
    localparam logic [GLYPH_W-1:0] GLYPH_AMP        = GLYPH_W'(37);
    localparam logic [GLYPH_W:0]   GLYPH_LIMIT      = (GLYPH_W+1)'(GLYPH_COUNT);

    // What one scan tick does
    typedef enum logic [1:0] {
        STEP_IDLE  = 2'd0,
        STEP_FONT  = 2'd1,
        STEP_ROW   = 2'd2,
        STEP_LATCH = 2'd3
    } step_kind_t;

    typedef struct packed {
        step_kind_t       kind;
        logic [2:0]       bit_idx;
        logic [ROW_W-1:0] row;
    } step_t;

    typedef struct packed {
        logic               known;
        logic [GLYPH_W-1:0] idx;
    } glyph_t;

    function automatic glyph_t glyph_of(input logic [7:0] code);
        glyph_t     g;
        logic [7:0] diff;
        g.known = 1'b0;
        g.idx   = '0;
        diff    = 8'h00;
        if (code >= CHAR_UPPER_A && code <= CHAR_UPPER_Z)
        begin
            diff    = code - CHAR_UPPER_A;
            g.known = 1'b1;
            g.idx   = diff[GLYPH_W-1:0];
        end
        else if (code >= CHAR_DIGIT_0 && code <= CHAR_DIGIT_9)
        begin
            diff    = code - CHAR_DIGIT_0;
            g.known = 1'b1;
            g.idx   = GLYPH_DIGIT_BASE + diff[GLYPH_W-1:0];
        end
        else if (code == CHAR_SPACE)
        begin
            g.known = 1'b1;
            g.idx   = GLYPH_SPACE;
        end
        else if (code == CHAR_AMP)
        begin
            g.known = 1'b1;
            g.idx   = GLYPH_AMP;
        end
        if (g.known && ({1'b0, g.idx} >= GLYPH_LIMIT))
        begin
            g.known = 1'b0;
        end
        return g;
    endfunction

endpackage
`default_nettype wire

// ===== sv/led_matrix_glyph_serial_scan_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// LED matrix glyph serial scanner
// Streams one glyph row frame per 17 scan ticks to a chained serial driver.
// ============================================================================
// Pipeline: 2 register stages (font read, output register); a scan tick is
// held in stage 1 while its font byte is read, then in the output register.
// Throughput: one item per cycle while in_stall is low; the font read port is used once per tick.
// Load items produce no result; they write the font store at accept.
// Reset: async, active low. After reset the font store is zeroed, one byte a
// cycle, all 304 bytes; in_stall stays high during that pass. APB writes work
// throughout.
module led_matrix_glyph_serial_scan_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // APB config port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [1:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    // input items
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic        cmd,
    input  wire logic [8:0]  font_address,
    input  wire logic [7:0]  font_byte,
    // result items
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic             serial_data,
    output logic             shift_pulse,
    output logic             latch_pulse
);

    localparam logic [7:0] DISPLAY_CHAR_RESET = 8'h20;

    // ---------------------------------------------------------------------
    // Configuration register (single register at offset 0)
    // ---------------------------------------------------------------------
    logic [7:0] display_char_reg;
    logic       cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign prdata    = {24'h000000, display_char_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            display_char_reg <= DISPLAY_CHAR_RESET;
        end
        else if (cfg_write && (paddr == lmgs_pkg::REG_DISPLAY_CHAR))
        begin
            display_char_reg <= pwdata[7:0];
        end
    end

    // ---------------------------------------------------------------------
    // Handshake: stage 1 holds a scan step while the font byte is read;
    // the output register holds the finished result.
    // ---------------------------------------------------------------------
    logic            s1_valid_reg;
    lmgs_pkg::step_t s1_step_reg;
    logic            out_valid_reg;
    logic            serial_reg, shift_reg, latch_reg;

    logic            out_free, s1_move, accept, scan_acc, load_acc;
    logic            store_busy;
    lmgs_pkg::step_t step;
    logic [lmgs_pkg::ADDR_W-1:0] rd_addr;
    logic [7:0]      font_rd_data;

    assign out_free = !out_valid_reg || !out_stall;
    assign s1_move  = s1_valid_reg && out_free;
    assign in_stall = store_busy || (s1_valid_reg && !out_free);
    assign accept   = in_valid && !in_stall;
    assign scan_acc = accept && (cmd != lmgs_pkg::CMD_LOAD);
    assign load_acc = accept && (cmd == lmgs_pkg::CMD_LOAD);

    // Phase / row state advances at accept so back-to-back ticks see it.
    lmgs_scan_seq u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .display_char (display_char_reg),
        .advance      (scan_acc),
        .step         (step),
        .rd_addr      (rd_addr)
    );

    // A load written into the font store is visible to any tick read at a later edge.
    lmgs_font_store u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (load_acc),
        .wr_addr (font_address),
        .wr_data (font_byte),
        .rd_en   (scan_acc),
        .rd_addr (rd_addr),
        .rd_data (font_rd_data),
        .busy    (store_busy)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (scan_acc)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_move)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (scan_acc)
        begin
            s1_step_reg <= step;
        end
    end

    // ---------------------------------------------------------------------
    // Result stage: font bits go out inverted (low drives the LED column),
    // then the one-hot row select, then the latch strobe.
    // ---------------------------------------------------------------------
    logic serial_next, shift_next, latch_next;

    always_comb
    begin
        serial_next = 1'b0;
        shift_next  = 1'b0;
        latch_next  = 1'b0;
        case (s1_step_reg.kind)
            lmgs_pkg::STEP_FONT:
            begin
                serial_next = ~font_rd_data[s1_step_reg.bit_idx];
                shift_next  = 1'b1;
            end
            lmgs_pkg::STEP_ROW:
            begin
                serial_next = (s1_step_reg.bit_idx == s1_step_reg.row);
                shift_next  = 1'b1;
            end
            lmgs_pkg::STEP_LATCH:
            begin
                latch_next = 1'b1;
            end
            default:
            begin
                serial_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_move)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            serial_reg <= serial_next;
            shift_reg  <= shift_next;
            latch_reg  <= latch_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign serial_data = serial_reg;
    assign shift_pulse = shift_reg;
    assign latch_pulse = latch_reg;

endmodule
`default_nettype wire

// ===== sv/lmgs_font_store.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// Font store
// Single-port-write, registered-read byte memory with a zeroing pass after
// reset.
// ============================================================================
module lmgs_font_store (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        wr_en,
    input  wire logic [lmgs_pkg::ADDR_W-1:0] wr_addr,
    input  wire logic [7:0]                  wr_data,
    input  wire logic                        rd_en,
    input  wire logic [lmgs_pkg::ADDR_W-1:0] rd_addr,
    output logic      [7:0]                  rd_data,
    output logic                             busy
);

    localparam logic [lmgs_pkg::ADDR_W-1:0] LAST_ADDR =
        lmgs_pkg::ADDR_W'(lmgs_pkg::STORE_DEPTH - 1);
    localparam logic [lmgs_pkg::ADDR_W-1:0] DEPTH_VAL =
        lmgs_pkg::ADDR_W'(lmgs_pkg::STORE_DEPTH);

    logic [7:0]                  mem [lmgs_pkg::STORE_DEPTH];
    logic                        clearing_reg;
    logic [lmgs_pkg::ADDR_W-1:0] clr_addr_reg;
    logic [7:0]                  rd_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg <= 1'b1;
            clr_addr_reg <= '0;
        end
        else if (clearing_reg)
        begin
            clr_addr_reg <= clr_addr_reg + 1'b1;
            if (clr_addr_reg == LAST_ADDR)
            begin
                clearing_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (clearing_reg)
        begin
            mem[clr_addr_reg] <= 8'h00;
        end
        else if (wr_en && (wr_addr < DEPTH_VAL))
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;
    assign busy    = clearing_reg;

endmodule
`default_nettype wire

// ===== sv/lmgs_scan_seq.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// Scan sequencer
// Holds frame phase and scan row; decodes the step for the current tick.
// ============================================================================
module lmgs_scan_seq (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic [7:0]                  display_char,
    input  wire logic                        advance,
    output lmgs_pkg::step_t                  step,
    output logic      [lmgs_pkg::ADDR_W-1:0] rd_addr
);

    localparam logic [lmgs_pkg::PHASE_W-1:0] FRAME_TICKS =
        lmgs_pkg::PHASE_W'(17);

    logic [lmgs_pkg::PHASE_W-1:0] phase_reg, phase_next, phase_eff;
    logic [lmgs_pkg::ROW_W-1:0]   row_reg, row_next;
    lmgs_pkg::glyph_t             glyph;

    always_comb
    begin
        glyph        = lmgs_pkg::glyph_of(display_char);
        phase_eff    = (phase_reg >= FRAME_TICKS) ? '0 : phase_reg;
        step.bit_idx = phase_eff[2:0];
        step.row     = row_reg;
        phase_next   = phase_eff + 1'b1;
        row_next     = row_reg;
        if (!glyph.known)
        begin
            step.kind  = lmgs_pkg::STEP_IDLE;
            phase_next = '0;
            row_next   = '0;
        end
        else if (phase_eff < lmgs_pkg::PHASE_ROW_START)
        begin
            step.kind = lmgs_pkg::STEP_FONT;
        end
        else if (phase_eff < lmgs_pkg::PHASE_LATCH)
        begin
            step.kind = lmgs_pkg::STEP_ROW;
        end
        else
        begin
            step.kind  = lmgs_pkg::STEP_LATCH;
            phase_next = '0;
            row_next   = row_reg + 1'b1;
        end
    end

    // glyph * 8 + row
    assign rd_addr = {glyph.idx, row_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= '0;
            row_reg   <= '0;
        end
        else if (advance)
        begin
            phase_reg <= phase_next;
            row_reg   <= row_next;
        end
    end

endmodule
`default_nettype wire
